// ===== design/usp_pkg.sv =====
package usp_pkg;

  localparam int unsigned TimeW  = 32;
  localparam int unsigned DurW   = 31;
  localparam int unsigned RouteW = 8;
  localparam int unsigned JobW   = 16;
  localparam int unsigned ErrW   = 8;
  localparam int unsigned PhaseW = 3;
  localparam int unsigned ModeW  = 3;
  localparam int unsigned CfgIdxW = 2;

  // event modes
  localparam logic [ModeW-1:0] MODE_UPDATE = 3'd0;
  localparam logic [ModeW-1:0] MODE_START  = 3'd1;
  localparam logic [ModeW-1:0] MODE_ABORT  = 3'd2;
  localparam logic [ModeW-1:0] MODE_FAIL   = 3'd3;
  localparam logic [ModeW-1:0] MODE_RESET  = 3'd4;
  localparam logic [ModeW-1:0] MODE_ACK    = 3'd5;

  // sequencer phases
  localparam logic [PhaseW-1:0] PH_IDLE    = 3'd0;
  localparam logic [PhaseW-1:0] PH_RELEASE = 3'd1;
  localparam logic [PhaseW-1:0] PH_WAIT    = 3'd2;
  localparam logic [PhaseW-1:0] PH_HOME    = 3'd3;
  localparam logic [PhaseW-1:0] PH_FAILED  = 3'd4;

  // result kinds
  localparam logic [1:0] KIND_COMPLETE = 2'd0;
  localparam logic [1:0] KIND_ABORTED  = 2'd1;
  localparam logic [1:0] KIND_FAILED   = 2'd2;
  localparam logic [1:0] KIND_TIMEOUT  = 2'd3;

  // servo drive codes
  localparam logic [1:0] DRIVE_OFF     = 2'd0;
  localparam logic [1:0] DRIVE_RELEASE = 2'd1;
  localparam logic [1:0] DRIVE_HOME    = 2'd2;

  // load sensor levels
  localparam logic [1:0] LOAD_EMPTY   = 2'd0;
  localparam logic [1:0] LOAD_PRESENT = 2'd1;

  localparam logic [ErrW-1:0] ERR_NONE    = 8'd0;
  localparam logic [ErrW-1:0] ERR_TIMEOUT = 8'd1;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_TIMEOUT = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_DEPLOY  = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_HOME    = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_ROUTES  = 2'd3;

  typedef struct packed {
    logic [ModeW-1:0]  mode;
    logic [TimeW-1:0]  now_ms;
    logic [1:0]        load_level;
    logic [JobW-1:0]   job_number;
    logic [RouteW-1:0] route_number;
    logic [TimeW-1:0]  requested_ms;
    logic [ErrW-1:0]   error_reason;
  } ev_t;

  typedef struct packed {
    logic              start_accepted;
    logic [1:0]        servo_drive;
    logic [PhaseW-1:0] phase;
    logic              result_valid;
    logic [1:0]        result_kind;
    logic [JobW-1:0]   result_job;
    logic [RouteW-1:0] result_route;
    logic [TimeW-1:0]  result_requested_ms;
    logic [TimeW-1:0]  result_completed_ms;
    logic [ErrW-1:0]   result_error;
  } rep_t;

endpackage

// ===== design/unload_servo_sequencer.sv =====
// Cargo-release servo sequencer.
// Events enter on the ev channel (ev_valid / ev_stall / ev); each accepted
// item produces exactly one report on the rep channel (rep_valid / rep_stall /
// rep) carrying servo drive, phase, start acceptance and the pending result.
// The sequencer state is updated at the edge that accepts the item, and the
// report register is loaded at that same edge from the next-state values.
// Throughput is one item per clock while rep_stall does not hold a report.
// A new item is taken while the report register is free or its report leaves
// in the same cycle; while the receiver holds rep_stall with a report waiting,
// ev_stall is raised and the report holds. Configuration writes (cfg_we,
// cfg_index, cfg_data) take effect at the next edge and are meant to happen
// while no item is in flight.
// Synchronous reset returns the phase to idle, clears the job and any pending
// result, loads the register defaults (timeout 30000 ms, deploy and home
// 800 ms, four routes) and empties the report register.
module unload_servo_sequencer
  import usp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               ev_valid,
  output logic               ev_stall,
  input  ev_t                ev,
  output logic               rep_valid,
  input  logic               rep_stall,
  output rep_t               rep,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [DurW-1:0]    cfg_data
);

  logic [DurW-1:0]   operation_timeout_ms;
  logic [DurW-1:0]   deploy_time_ms;
  logic [DurW-1:0]   home_time_ms;
  logic [RouteW-1:0] route_count;

  logic [PhaseW-1:0] phase_reg, phase_reg_next;
  logic              busy, busy_next;
  logic [TimeW-1:0]  start_time, start_time_next;
  logic [TimeW-1:0]  phase_time, phase_time_next;
  logic              load_seen, load_seen_next;
  logic              result_ready, result_ready_next;
  logic [JobW-1:0]   cmd_job, cmd_job_next;
  logic [RouteW-1:0] cmd_route, cmd_route_next;
  logic [TimeW-1:0]  cmd_requested, cmd_requested_next;
  logic [1:0]        res_kind, res_kind_next;
  logic [JobW-1:0]   res_job, res_job_next;
  logic [RouteW-1:0] res_route, res_route_next;
  logic [TimeW-1:0]  res_requested, res_requested_next;
  logic [TimeW-1:0]  res_completed, res_completed_next;
  logic [ErrW-1:0]   res_error, res_error_next;

  logic              accept;
  logic              accepted;
  logic              do_latch;
  logic [1:0]        latch_kind;
  logic [ErrW-1:0]   latch_err;
  logic [TimeW-1:0]  timeout_diff, deploy_diff, home_diff;
  logic              timeout_hit, deploy_hit, home_hit;
  logic              start_ok;
  logic [1:0]        drive;
  rep_t              rep_next;

  assign ev_stall = rep_valid && rep_stall;
  assign accept   = ev_valid && !ev_stall;

  // wrap-safe deadline checks: reached when the signed difference is not negative
  assign timeout_diff = ev.now_ms - start_time - {1'b0, operation_timeout_ms};
  assign deploy_diff  = ev.now_ms - phase_time - {1'b0, deploy_time_ms};
  assign home_diff    = ev.now_ms - phase_time - {1'b0, home_time_ms};
  assign timeout_hit  = !timeout_diff[TimeW-1];
  assign deploy_hit   = !deploy_diff[TimeW-1];
  assign home_hit     = !home_diff[TimeW-1];

  assign start_ok = !busy && (phase_reg == PH_IDLE) && !result_ready &&
                    (ev.job_number != '0) && (ev.route_number != '0) &&
                    (ev.route_number <= route_count);

  always_comb begin
    phase_reg_next     = phase_reg;
    busy_next          = busy;
    start_time_next    = start_time;
    phase_time_next    = phase_time;
    load_seen_next     = load_seen;
    cmd_job_next       = cmd_job;
    cmd_route_next     = cmd_route;
    cmd_requested_next = cmd_requested;
    accepted           = 1'b0;
    do_latch           = 1'b0;
    latch_kind         = KIND_COMPLETE;
    latch_err          = ERR_NONE;
    result_ready_next  = result_ready;

    case (ev.mode)
      MODE_UPDATE: begin
        if (busy) begin
          if (ev.load_level == LOAD_PRESENT) begin
            load_seen_next = 1'b1;
          end
          if (timeout_hit) begin
            busy_next       = 1'b0;
            phase_reg_next  = PH_FAILED;
            phase_time_next = ev.now_ms;
            do_latch        = 1'b1;
            latch_kind      = KIND_TIMEOUT;
            latch_err       = ERR_TIMEOUT;
          end else begin
            case (phase_reg)
              PH_RELEASE: begin
                if (deploy_hit) begin
                  phase_reg_next  = PH_WAIT;
                  phase_time_next = ev.now_ms;
                end
              end
              PH_WAIT: begin
                if (load_seen_next && ev.load_level == LOAD_EMPTY) begin
                  phase_reg_next  = PH_HOME;
                  phase_time_next = ev.now_ms;
                end
              end
              PH_HOME: begin
                if (home_hit) begin
                  busy_next       = 1'b0;
                  phase_reg_next  = PH_IDLE;
                  phase_time_next = ev.now_ms;
                  do_latch        = 1'b1;
                  latch_kind      = KIND_COMPLETE;
                end
              end
              default: ;
            endcase
          end
        end
      end
      MODE_START: begin
        if (start_ok) begin
          cmd_job_next       = ev.job_number;
          cmd_route_next     = ev.route_number;
          cmd_requested_next = ev.requested_ms;
          phase_reg_next     = PH_RELEASE;
          start_time_next    = ev.now_ms;
          phase_time_next    = ev.now_ms;
          busy_next          = 1'b1;
          load_seen_next     = 1'b0;
          accepted           = 1'b1;
        end
      end
      MODE_ABORT, MODE_FAIL: begin
        if (busy) begin
          busy_next       = 1'b0;
          phase_reg_next  = (ev.mode == MODE_ABORT) ? PH_IDLE : PH_FAILED;
          start_time_next = ev.now_ms;
          phase_time_next = ev.now_ms;
          load_seen_next  = 1'b0;
          do_latch        = 1'b1;
          latch_kind      = (ev.mode == MODE_ABORT) ? KIND_ABORTED : KIND_FAILED;
          latch_err       = ev.error_reason;
        end
      end
      MODE_RESET: begin
        busy_next          = 1'b0;
        phase_reg_next     = PH_IDLE;
        start_time_next    = ev.now_ms;
        phase_time_next    = ev.now_ms;
        load_seen_next     = 1'b0;
        result_ready_next  = 1'b0;
        cmd_job_next       = '0;
        cmd_route_next     = '0;
        cmd_requested_next = '0;
      end
      MODE_ACK: begin
        result_ready_next = 1'b0;
      end
      default: ;
    endcase
  end

  // latch a record only when none is pending; an existing one stays
  always_comb begin
    res_kind_next      = res_kind;
    res_job_next       = res_job;
    res_route_next     = res_route;
    res_requested_next = res_requested;
    res_completed_next = res_completed;
    res_error_next     = res_error;
    if (do_latch && !result_ready) begin
      res_kind_next      = latch_kind;
      res_job_next       = cmd_job;
      res_route_next     = cmd_route;
      res_requested_next = cmd_requested;
      res_completed_next = ev.now_ms;
      res_error_next     = latch_err;
    end
  end

  always_comb begin
    case (phase_reg_next)
      PH_RELEASE, PH_WAIT: drive = DRIVE_RELEASE;
      PH_HOME:             drive = DRIVE_HOME;
      default:             drive = DRIVE_OFF;
    endcase
  end

  logic res_held;
  assign res_held = result_ready_next || (do_latch && !result_ready);

  always_comb begin
    rep_next                = '0;
    rep_next.start_accepted = accepted;
    rep_next.servo_drive    = drive;
    rep_next.phase          = phase_reg_next;
    rep_next.result_valid   = res_held;
    if (res_held) begin
      rep_next.result_kind         = res_kind_next;
      rep_next.result_job          = res_job_next;
      rep_next.result_route        = res_route_next;
      rep_next.result_requested_ms = res_requested_next;
      rep_next.result_completed_ms = res_completed_next;
      rep_next.result_error        = res_error_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      operation_timeout_ms <= DurW'(30000);
      deploy_time_ms       <= DurW'(800);
      home_time_ms         <= DurW'(800);
      route_count          <= RouteW'(4);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TIMEOUT: operation_timeout_ms <= cfg_data;
        REG_DEPLOY:  deploy_time_ms <= cfg_data;
        REG_HOME:    home_time_ms <= cfg_data;
        REG_ROUTES:  route_count <= cfg_data[RouteW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_reg     <= PH_IDLE;
      busy          <= 1'b0;
      start_time    <= '0;
      phase_time    <= '0;
      load_seen     <= 1'b0;
      result_ready  <= 1'b0;
      cmd_job       <= '0;
      cmd_route     <= '0;
      cmd_requested <= '0;
      res_kind      <= '0;
      res_job       <= '0;
      res_route     <= '0;
      res_requested <= '0;
      res_completed <= '0;
      res_error     <= '0;
    end else if (accept) begin
      phase_reg     <= phase_reg_next;
      busy          <= busy_next;
      start_time    <= start_time_next;
      phase_time    <= phase_time_next;
      load_seen     <= load_seen_next;
      result_ready  <= res_held;
      cmd_job       <= cmd_job_next;
      cmd_route     <= cmd_route_next;
      cmd_requested <= cmd_requested_next;
      res_kind      <= res_kind_next;
      res_job       <= res_job_next;
      res_route     <= res_route_next;
      res_requested <= res_requested_next;
      res_completed <= res_completed_next;
      res_error     <= res_error_next;
    end
  end

  // report register: load on accept, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rep_valid <= 1'b0;
    end else if (accept) begin
      rep_valid <= 1'b1;
    end else if (!rep_stall) begin
      rep_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rep <= rep_next;
    end
  end

  a_busy_phase: assert property (@(posedge clk) disable iff (rst)
    busy |-> (phase_reg == PH_RELEASE || phase_reg == PH_WAIT || phase_reg == PH_HOME))
    else $error("busy outside an active phase");

  a_idle_phase: assert property (@(posedge clk) disable iff (rst)
    !busy |-> (phase_reg == PH_IDLE || phase_reg == PH_FAILED))
    else $error("active phase while not busy");

  a_busy_rise: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> ($past(accept) && $past(ev.mode) == MODE_START))
    else $error("job started without an accepted start item");

  a_result_drop: assert property (@(posedge clk) disable iff (rst)
    $fell(result_ready) |->
      ($past(accept) && ($past(ev.mode) == MODE_RESET || $past(ev.mode) == MODE_ACK)))
    else $error("pending result lost without acknowledge or reset");

  a_report_clear: assert property (@(posedge clk) disable iff (rst)
    (rep_valid && !rep.result_valid) |->
      (rep.result_job == '0 && rep.result_completed_ms == '0 && rep.result_error == '0))
    else $error("result fields set with no pending result");

endmodule
